>>> rtl/lgs_pkg.sv
// Shared types and constants for the life grid generation step unit.
// Depends on nothing; imported by the top level.
`timescale 1ns / 1ps

package lgs_pkg;

  // input and result field widths fixed by the interface
  localparam int ACTION_W = 2;
  localparam int INDEX_W  = 6;
  localparam int CELL_W   = 32;

  typedef logic [ACTION_W-1:0] action_t;

  // request actions
  localparam action_t ACT_WRITE = 2'd0;
  localparam action_t ACT_READ  = 2'd1;
  localparam action_t ACT_STEP  = 2'd2;
  localparam action_t ACT_CLEAR = 2'd3;

  // birth and survival neighbor counts of the B3/S23 rule
  localparam int BIRTH_COUNT   = 3;
  localparam int SURVIVE_COUNT = 2;

endpackage

>>> rtl/lgs_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module lgs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 48
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/lgs_row_rule.sv
// Row rule unit: next generation of one row from the rows above, at and below it.
// Depends on lgs_pkg for the rule counts.
`timescale 1ns / 1ps

module lgs_row_rule import lgs_pkg::*; #(
  parameter int WIDTH = 32
) (
  input  logic [WIDTH-1:0] above,
  input  logic [WIDTH-1:0] mid,
  input  logic [WIDTH-1:0] below,
  output logic [WIDTH-1:0] next_row
);

  // rows padded with a dead column on each side
  logic [WIDTH+1:0] above_p;
  logic [WIDTH+1:0] mid_p;
  logic [WIDTH+1:0] below_p;

  assign above_p = {1'b0, above, 1'b0};
  assign mid_p   = {1'b0, mid, 1'b0};
  assign below_p = {1'b0, below, 1'b0};

  // per column neighbor count and rule, columns are independent
  always_comb begin
    logic [3:0] cnt;
    next_row = '0;
    for (int x = 0; x < WIDTH; x++) begin
      cnt = 4'(above_p[x]) + 4'(above_p[x+1]) + 4'(above_p[x+2])
          + 4'(mid_p[x]) + 4'(mid_p[x+2])
          + 4'(below_p[x]) + 4'(below_p[x+1]) + 4'(below_p[x+2]);
      next_row[x] = (cnt == 4'(BIRTH_COUNT))
                 || (mid[x] && (cnt == 4'(SURVIVE_COUNT)));
    end
  end

endmodule

>>> rtl/life_grid_generation_step_unit.sv
// Bounded Game of Life grid (B3/S23, dead border) held in a RAM of GRID_HEIGHT rows.
// Each request gives one result. Write and clear go straight to the response state,
// read goes through a read state and a generation through a sweep state: the sweep reads one row per
// cycle from the grid RAM, keeps a three-row window and writes each new row back
// through one row rule unit. The grid is cleared at reset by per-row valid bits.
// Depends on lgs_pkg, lgs_ram and lgs_row_rule.
`timescale 1ns / 1ps

module life_grid_generation_step_unit import lgs_pkg::*; #(
  parameter int GRID_WIDTH  = 32,
  parameter int GRID_HEIGHT = 48
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  action_t             in_action,
  input  logic [INDEX_W-1:0]  in_row_index,
  input  logic [CELL_W-1:0]   in_row_cells,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [CELL_W-1:0]   out_row_value
);

  localparam int RW = $clog2(GRID_HEIGHT);
  localparam int JW = $clog2(GRID_HEIGHT + 2);
  localparam int CW = (GRID_WIDTH < CELL_W) ? GRID_WIDTH : CELL_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_GEN  = 2'd2;
  localparam logic [1:0] ST_RESP = 2'd3;

  logic [1:0]             state_r, state_nxt;
  logic [JW-1:0]          j_r, j_nxt;
  logic [GRID_WIDTH-1:0]  prev_r, prev_nxt;
  logic [GRID_WIDTH-1:0]  cur_r, cur_nxt;
  logic [CELL_W-1:0]      res_r, res_nxt;
  logic [GRID_HEIGHT-1:0] valid_r, valid_nxt;
  logic                   rd_live_r, rd_live_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [CELL_W-1:0]      out_row_value_r;

  logic                   accept;
  logic                   idx_ok;
  logic [RW-1:0]          in_addr;
  logic                   gen_rd;
  logic                   gen_wr;
  logic                   host_wr;
  logic                   out_load;
  logic [GRID_WIDTH-1:0]  rdata;
  logic [GRID_WIDTH-1:0]  incoming;
  logic [GRID_WIDTH-1:0]  rule_row;
  logic                   ram_we;
  logic [RW-1:0]          ram_waddr;
  logic [GRID_WIDTH-1:0]  ram_wdata;
  logic [RW-1:0]          ram_raddr;
  logic [RW-1:0]          gen_raddr;
  logic [RW-1:0]          gen_waddr;

  // request handshake and decode
  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign idx_ok   = (int'(in_row_index) < GRID_HEIGHT);
  assign in_addr  = RW'(in_row_index);
  assign host_wr  = accept && (in_action == ACT_WRITE) && idx_ok;

  // generation sweep addressing: read row j, write row j-2
  assign gen_rd    = (state_r == ST_GEN) && (j_r < JW'(GRID_HEIGHT));
  assign gen_wr    = (state_r == ST_GEN) && (j_r >= JW'(2));
  assign gen_raddr = RW'(j_r);
  assign gen_waddr = RW'(j_r - JW'(2));

  // rows never written since reset or clear read as dead
  assign incoming = rd_live_r ? rdata : '0;

  // grid RAM ports
  assign ram_raddr = (state_r == ST_GEN) ? gen_raddr : in_addr;
  assign ram_we    = host_wr || gen_wr;
  assign ram_waddr = gen_wr ? gen_waddr : in_addr;
  assign ram_wdata = gen_wr ? rule_row : GRID_WIDTH'(in_row_cells[CW-1:0]);

  lgs_ram #(
    .WIDTH(GRID_WIDTH),
    .DEPTH(GRID_HEIGHT)
  ) u_grid (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(rdata)
  );

  // shared row rule over the three-row window
  lgs_row_rule #(
    .WIDTH(GRID_WIDTH)
  ) u_rule (
    .above   (prev_r),
    .mid     (cur_r),
    .below   (incoming),
    .next_row(rule_row)
  );

  // row valid bits
  always_comb begin
    valid_nxt = valid_r;
    if (accept && (in_action == ACT_CLEAR)) begin
      valid_nxt = '0;
    end
    if (host_wr) begin
      valid_nxt[in_addr] = 1'b1;
    end
    if (gen_wr) begin
      valid_nxt[gen_waddr] = 1'b1;
    end
  end

  // read data qualifier for the row read last cycle
  assign rd_live_nxt = (accept && (in_action == ACT_READ) && idx_ok && valid_r[in_addr])
                    || (gen_rd && valid_r[gen_raddr]);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    j_nxt     = j_r;
    prev_nxt  = prev_r;
    cur_nxt   = cur_r;
    res_nxt   = res_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          res_nxt = '0;
          case (in_action)
            ACT_READ: begin
              state_nxt = ST_READ;
            end
            ACT_STEP: begin
              j_nxt     = '0;
              prev_nxt  = '0;
              cur_nxt   = '0;
              state_nxt = ST_GEN;
            end
            default: begin
              state_nxt = ST_RESP;
            end
          endcase
        end
      end
      ST_READ: begin
        res_nxt   = CELL_W'(incoming[CW-1:0]);
        state_nxt = ST_RESP;
      end
      ST_GEN: begin
        j_nxt    = j_r + JW'(1);
        prev_nxt = cur_r;
        cur_nxt  = incoming;
        if (j_r == JW'(GRID_HEIGHT + 1)) begin
          res_nxt   = '0;
          state_nxt = ST_RESP;
        end
      end
      ST_RESP: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // result register
  assign out_load      = (state_r == ST_RESP) && (!out_valid_r || !out_stall);
  assign out_valid_nxt = out_load || (out_valid_r && out_stall);

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      j_r         <= '0;
      valid_r     <= '0;
      rd_live_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      j_r         <= j_nxt;
      valid_r     <= valid_nxt;
      rd_live_r   <= rd_live_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    prev_r <= prev_nxt;
    cur_r  <= cur_nxt;
    res_r  <= res_nxt;
    if (out_load) begin
      out_row_value_r <= res_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_row_value = out_row_value_r;

endmodule
